// ----- rtl/afsd_pkg.sv -----
// ----------------------------------------------------------------------------
// afsd_pkg
// Shared types, codes and constants of the alive-filter stream deframer.
// ----------------------------------------------------------------------------
package afsd_pkg;

  localparam int unsigned AFSD_CMD_DEPTH = 4;
  localparam logic [7:0]  AFSD_MAX_LEN_RESET = 8'd16;

  localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
  localparam logic [7:0] CH_SEP   = 8'h3B;  // ';'
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_V     = 8'h56;
  localparam logic [7:0] CH_E     = 8'h45;

  localparam logic [2:0] LOGIN_SEP_RUNS = 3'd3;
  localparam logic [2:0] SEP_RUNS_MAX   = 3'd7;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_LOGIN   = 3'd2,
    KIND_ACCEPT  = 3'd3,
    KIND_REJECT  = 3'd4,
    KIND_BADSTRT = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    MODE_INITIAL = 4'd0,
    MODE_LOGIN   = 4'd1,
    MODE_STREAM  = 4'd2,
    MODE_ALV_A   = 4'd3,
    MODE_ALV_L   = 4'd4,
    MODE_ALV_I   = 4'd5,
    MODE_ALV_V   = 4'd6,
    MODE_ALV_E   = 4'd7,
    MODE_BODY    = 4'd8,
    MODE_ERROR   = 4'd9
  } mode_t;

  // One command from the front to the back: npre prefix bytes of the
  // watchdog tag are replayed first, then one result of the given kind.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] npre;
  } cmd_t;

  // Character expected at a given position of the word "ALIVE".
  function automatic logic [7:0] alive_char(input logic [2:0] pos);
    logic [7:0] ch;
    unique case (pos)
      3'd0:    ch = CH_A;
      3'd1:    ch = CH_L;
      3'd2:    ch = CH_I;
      3'd3:    ch = CH_V;
      default: ch = CH_E;
    endcase
    return ch;
  endfunction

  // Byte k of the replayed prefix "<ALIVE".
  function automatic logic [7:0] prefix_byte(input logic [2:0] k);
    logic [7:0] ch;
    if (k == 3'd0) begin
      ch = CH_OPEN;
    end else begin
      ch = alive_char(k - 3'd1);
    end
    return ch;
  endfunction

endpackage

// ----- rtl/afsd_front.sv -----
// ----------------------------------------------------------------------------
// afsd_front
// Classifies each received byte, keeps the framing state and issues one
// command per byte that produces results.
// ----------------------------------------------------------------------------
module afsd_front
  import afsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output logic       cmd_push,
  output cmd_t       cmd
);

  mode_t      mode, mode_next;
  logic [7:0] watchdog_count, watchdog_count_next;
  logic [2:0] separator_runs, separator_runs_next;
  logic       in_separator_run, in_separator_run_next;
  logic [7:0] alive_max_len;

  logic [2:0] pos;
  logic       tag_match;
  logic [8:0] body_count;

  assign pos        = 3'(mode - MODE_ALV_A);
  assign tag_match  = (in_byte == alive_char(pos));
  assign body_count = {1'b0, watchdog_count} + 9'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_INITIAL;
      watchdog_count   <= '0;
      separator_runs   <= '0;
      in_separator_run <= 1'b0;
      alive_max_len    <= AFSD_MAX_LEN_RESET;
    end else begin
      if (accept) begin
        mode             <= mode_next;
        watchdog_count   <= watchdog_count_next;
        separator_runs   <= separator_runs_next;
        in_separator_run <= in_separator_run_next;
      end
      if (cfg_write) begin
        alive_max_len <= cfg_data;
      end
    end
  end

  // Next state.
  always_comb begin
    mode_next             = mode;
    watchdog_count_next   = watchdog_count;
    separator_runs_next   = separator_runs;
    in_separator_run_next = in_separator_run;
    unique case (mode)
      MODE_INITIAL: begin
        mode_next = (in_byte == CH_OPEN) ? MODE_LOGIN : MODE_ERROR;
      end
      MODE_LOGIN: begin
        if (in_byte == CH_CLOSE) begin
          mode_next = (separator_runs == LOGIN_SEP_RUNS) ? MODE_STREAM : MODE_ERROR;
          separator_runs_next   = '0;
          in_separator_run_next = 1'b0;
        end else if (in_byte == CH_SEP) begin
          if (!in_separator_run && separator_runs != SEP_RUNS_MAX) begin
            separator_runs_next = separator_runs + 3'd1;
          end
          in_separator_run_next = 1'b1;
        end else begin
          in_separator_run_next = 1'b0;
        end
      end
      MODE_STREAM: begin
        if (in_byte == CH_OPEN) begin
          mode_next = MODE_ALV_A;
        end
      end
      MODE_ALV_A, MODE_ALV_L, MODE_ALV_I, MODE_ALV_V, MODE_ALV_E: begin
        if (!tag_match) begin
          mode_next = MODE_STREAM;
        end else if (mode == MODE_ALV_E) begin
          mode_next           = MODE_BODY;
          watchdog_count_next = '0;
        end else begin
          mode_next = mode_t'(mode + 4'd1);
        end
      end
      MODE_BODY: begin
        if (in_byte == CH_CLOSE) begin
          mode_next = MODE_STREAM;
        end else begin
          watchdog_count_next = body_count[8] ? 8'hFF : body_count[7:0];
          if (body_count > {1'b0, alive_max_len}) begin
            mode_next = MODE_STREAM;
          end
        end
      end
      MODE_ERROR: begin
        mode_next = MODE_ERROR;
      end
      default: begin
        mode_next = MODE_ERROR;
      end
    endcase
  end

  // Command issued for the accepted byte.
  always_comb begin
    cmd_push  = 1'b0;
    cmd.kind  = KIND_NONE;
    cmd.data  = '0;
    cmd.npre  = '0;
    unique case (mode)
      MODE_INITIAL: begin
        if (in_byte != CH_OPEN) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_BADSTRT;
        end
      end
      MODE_LOGIN: begin
        cmd_push = 1'b1;
        if (in_byte == CH_CLOSE) begin
          cmd.kind = (separator_runs == LOGIN_SEP_RUNS) ? KIND_ACCEPT : KIND_REJECT;
        end else begin
          cmd.kind = KIND_LOGIN;
          cmd.data = in_byte;
        end
      end
      MODE_STREAM: begin
        if (in_byte != CH_OPEN) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_DATA;
          cmd.data = in_byte;
        end
      end
      MODE_ALV_A, MODE_ALV_L, MODE_ALV_I, MODE_ALV_V, MODE_ALV_E: begin
        // A broken tag replays '<' and the matched letters before this byte.
        if (!tag_match) begin
          cmd_push = 1'b1;
          cmd.kind = KIND_DATA;
          cmd.data = in_byte;
          cmd.npre = pos + 3'd1;
        end
      end
      MODE_BODY: begin
        cmd_push = 1'b0;
      end
      MODE_ERROR: begin
        cmd_push = 1'b0;
      end
      default: begin
        cmd_push = 1'b0;
      end
    endcase
    cmd_push = cmd_push & accept;
  end

endmodule

// ----- rtl/afsd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// afsd_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module afsd_cmd_fifo
  import afsd_pkg::*;
#(
  parameter int unsigned DEPTH = AFSD_CMD_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  input  logic rd_en,
  output cmd_t rd_cmd,
  output logic full,
  output logic not_empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  cmd_t            entries [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == CntFull);
  assign not_empty = (count != '0);
  assign rd_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/afsd_back.sv -----
// ----------------------------------------------------------------------------
// afsd_back
// Expands each command into its results in the output register, one beat
// per cycle while the output register is free or popped.
// ----------------------------------------------------------------------------
module afsd_back
  import afsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       cmd,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  logic       pop,
  output logic       empty,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       out_valid;
  logic [2:0] step;
  logic       load;
  logic       final_beat;

  assign empty      = !out_valid;
  assign load       = cmd_valid && (!out_valid || pop);
  assign final_beat = (step == cmd.npre);
  assign cmd_pop    = load && final_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= final_beat ? 3'd0 : step + 3'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (final_beat) begin
        out_kind <= cmd.kind;
        out_byte <= cmd.data;
        out_last <= 1'b1;
      end else begin
        out_kind <= KIND_DATA;
        out_byte <= prefix_byte(step);
        out_last <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/alive_filter_stream_deframer_core.sv -----
// ----------------------------------------------------------------------------
// alive_filter_stream_deframer_core
// Login-header check and watchdog-frame removal on a byte stream.
// ----------------------------------------------------------------------------
// Input channel: a byte is taken on in_byte when push is high and full is
// low. Result channel: while empty is low, out_kind, out_byte and out_last
// show the oldest result; pop takes it. A byte may cause no result, one
// result, or up to six when a broken watchdog tag is replayed; out_last
// marks the final result of each byte.
// The front part updates the framing state in the cycle a byte is taken,
// so a byte can be taken every cycle while full is low. Its command enters
// a short queue, from which the back part loads the output register.
// The back part sends one result beat per cycle while the receiver pops,
// so a replay holds the result side while the queue keeps taking input.
// When the receiver stalls, the queue fills and full rises.
// Reset sets the block back to wait for the opening bracket, empties the
// queue and loads alive_max_len with 16. cfg_write loads cfg_data into
// alive_max_len at the clock edge.
// ----------------------------------------------------------------------------
module alive_filter_stream_deframer_core
  import afsd_pkg::*;
#(
  parameter int unsigned CMD_DEPTH = AFSD_CMD_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic accept;
  logic cmd_push;
  logic cmd_pop;
  logic cmd_valid;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  assign accept = push && !full;

  afsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (in_byte),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_push  (cmd_push),
    .cmd       (wr_cmd)
  );

  afsd_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_push),
    .wr_cmd    (wr_cmd),
    .rd_en     (cmd_pop),
    .rd_cmd    (rd_cmd),
    .full      (full),
    .not_empty (cmd_valid)
  );

  afsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rd_cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .out_kind  (out_kind),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
